// ----- rtl/cdq_pkg.sv -----
// Package for the circular deque block: opcode and status codes, the
// datapath command set and the command/status structs between its modules.
// No dependencies.
package cdq_pkg;

  localparam int unsigned OpcodeW = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned ValueW  = 32;

  typedef enum logic [OpcodeW-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DISPLAY    = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_REPORT,
    CMD_DISP_START,
    CMD_DISP_READ,
    CMD_DISP_EMIT
  } cmd_e;

  typedef struct packed {
    cmd_e    cmd;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic disp_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/cdq_ctrl.sv -----
// Controller of the circular deque: decodes each accepted transaction and
// sequences the display read-out. Depends on cdq_pkg.
module cdq_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cdq_pkg::OpcodeW-1:0]  opcode_i,
  input  cdq_pkg::dp_sts_t             sts_i,
  output cdq_pkg::dp_cmd_t             cmd_o
);
  import cdq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = !((state_q == ST_IDLE) && sts_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d       = state_q;
    cmd_o.cmd     = CMD_NONE;
    cmd_o.status  = STATUS_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (sts_i.full) begin
                cmd_o.cmd    = CMD_REPORT;
                cmd_o.status = STATUS_OVERFLOW;
              end else begin
                cmd_o.cmd = (opcode_i == OP_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (sts_i.empty) begin
                cmd_o.cmd    = CMD_REPORT;
                cmd_o.status = STATUS_UNDERFLOW;
              end else begin
                cmd_o.cmd = (opcode_i == OP_POP_FRONT) ? CMD_POP_FRONT : CMD_POP_BACK;
              end
            end
            OP_DISPLAY: begin
              if (sts_i.empty) begin
                cmd_o.cmd    = CMD_REPORT;
                cmd_o.status = STATUS_UNDERFLOW;
              end else begin
                cmd_o.cmd = CMD_DISP_START;
                state_d   = ST_READ;
              end
            end
            default: cmd_o.cmd = CMD_NONE;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.cmd = CMD_DISP_READ;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.cmd = CMD_DISP_EMIT;
          state_d   = sts_i.disp_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/cdq_dpath.sv -----
// Datapath of the circular deque: entry memory, front pointer, entry count,
// display offset and the output register. Depends on cdq_pkg.
module cdq_dpath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [cdq_pkg::ValueW-1:0] push_value_i,
  input  cdq_pkg::dp_cmd_t                  cmd_i,
  output cdq_pkg::dp_sts_t                  sts_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cdq_pkg::ValueW-1:0] entry_value_o,
  output logic [cdq_pkg::StatusW-1:0]       status_o,
  output logic                              last_o
);
  import cdq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [SumW-1:0] DepthSum = SumW'(DEPTH);

  logic [ValueW-1:0] mem_q [DEPTH];
  logic [ValueW-1:0] rd_q;

  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] offset_q, offset_d;
  logic            out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q;
  logic [StatusW-1:0] out_status_q;
  logic            out_last_q;

  logic [IdxW-1:0] front_prev, front_next, back_idx, disp_idx;
  logic [SumW-1:0] back_sum, disp_sum;
  logic            load;

  always_comb begin
    front_prev = (front_q == '0) ? LastIdx : front_q - 1'b1;
    front_next = (front_q == LastIdx) ? '0 : front_q + 1'b1;
    back_sum   = SumW'(front_q) + SumW'(count_q);
    if (back_sum >= DepthSum) back_sum = back_sum - DepthSum;
    disp_sum   = SumW'(front_q) + SumW'(offset_q);
    if (disp_sum >= DepthSum) disp_sum = disp_sum - DepthSum;
    back_idx   = back_sum[IdxW-1:0];
    disp_idx   = disp_sum[IdxW-1:0];
  end

  assign sts_o.full      = (count_q == DepthCnt);
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.disp_last = ((offset_q + 1'b1) == count_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign load = (cmd_i.cmd == CMD_PUSH_FRONT) || (cmd_i.cmd == CMD_PUSH_BACK) ||
                (cmd_i.cmd == CMD_POP_FRONT) || (cmd_i.cmd == CMD_POP_BACK) ||
                (cmd_i.cmd == CMD_REPORT) || (cmd_i.cmd == CMD_DISP_EMIT);

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    offset_d    = offset_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (cmd_i.cmd)
      CMD_PUSH_FRONT: begin
        front_d = front_prev;
        count_d = count_q + 1'b1;
      end
      CMD_PUSH_BACK: count_d = count_q + 1'b1;
      CMD_POP_FRONT: begin
        front_d = front_next;
        count_d = count_q - 1'b1;
      end
      CMD_POP_BACK:   count_d  = count_q - 1'b1;
      CMD_DISP_START: offset_d = '0;
      CMD_DISP_EMIT:  offset_d = offset_q + 1'b1;
      default: ;
    endcase
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      offset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      offset_q    <= offset_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == CMD_PUSH_FRONT) begin
      mem_q[front_prev] <= push_value_i;
    end else if (cmd_i.cmd == CMD_PUSH_BACK) begin
      mem_q[back_idx] <= push_value_i;
    end
    if (cmd_i.cmd == CMD_DISP_READ) begin
      rd_q <= mem_q[disp_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_value_q  <= (cmd_i.cmd == CMD_DISP_EMIT) ? rd_q : '0;
      out_status_q <= (cmd_i.cmd == CMD_REPORT) ? cmd_i.status : STATUS_OK;
      out_last_q   <= (cmd_i.cmd == CMD_DISP_EMIT) ? sts_o.disp_last : 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = out_value_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthCnt)
    else $error("entry count exceeds the depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_valid_q) |-> !out_stall_i)
    else $error("output register overwritten while its transaction is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + 1'b1 || count_q == $past(count_q) - 1'b1))
    else $error("entry count moved by more than one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cmd == CMD_DISP_EMIT) |-> (offset_q < count_q))
    else $error("display read past the back entry");

endmodule

// ----- rtl/circular_deque.sv -----
// Circular deque: bounded double-ended queue of signed 32-bit values held in
// a ring of DEPTH entries.
//
// Usage: each input transaction (in_valid_i high, in_stall_o low) carries an
// opcode and a push value. Push front/back store the value or report
// overflow when full; pop front/back drop an entry or report underflow when
// empty; display streams every entry from front to back with last_o on the
// back entry, or a single underflow result when empty. Unused opcodes are
// accepted and produce nothing.
// Timing: a push or pop result appears in the output register in the cycle
// after acceptance, so these operations run at one transaction per cycle
// while out_stall_i is low. A display reads each entry from the memory and
// then loads it into the output register, as the entry memory has a
// registered read port; input is held off until the back entry is loaded.
// Reset: rst_ni clears the front pointer, the entry count and all control
// state; the deque is empty. The entry memory is not cleared.
// Output stall: the output register holds its transaction while out_stall_i
// is high; input stays stalled until that register can take a new result.
module circular_deque #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cdq_pkg::OpcodeW-1:0]       opcode_i,
  input  logic signed [cdq_pkg::ValueW-1:0] push_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cdq_pkg::ValueW-1:0] entry_value_o,
  output logic [cdq_pkg::StatusW-1:0]       status_o,
  output logic                              last_o
);
  import cdq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller decodes transactions and sequences the display.
  cdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns the ring, its pointers and the output register.
  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_value_i  (push_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .entry_value_o (entry_value_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule
